// ===== rtl/assert_macros.svh =====
// Assertion macros used by the queue top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, masked while reset is held.
`define QRM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define QRM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/qrm_pkg.sv =====
// Shared types and constants for the running-max queue.
package qrm_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    // Fixed field widths on the stream ports
    localparam int IN_VALUE_W = 32;
    localparam int MAX_W      = 32;
    localparam int FILL_W     = 5;
    localparam int STATUS_W   = 2;
    localparam int OUT_DATA_W = 40;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } t_status;

    // Broadcast command to every candidate cell
    typedef struct packed {
        logic push;   // insert new value, dropping smaller ones at the back
        logic shift;  // drop front candidate, everything moves one place forward
    } t_cell_cmd;

endpackage

// ===== rtl/queue_with_running_max.sv =====
// Top level: FIFO bookkeeping plus a row of candidate cells giving the running max.
//
//  channel | dir | tdata                              | tuser
//  s       | in  | value[31:0]                        | operation[0] (0 push, 1 pop)
//  m       | out | max[31:0] empty[32] fill[37:33]    | -
//          |     | status[39:38]                      |
//
// One transaction per clock unless the output stalls; each cell decides its next
// contents from the broadcast command and its neighbors alone, so the result is ready
// the cycle after acceptance. The cell registers and the fill count are the result: an
// input is taken only when the pending result is taken in the same cycle or none is
// pending. Synchronous active-low reset empties the queue; no clearing pass is needed.
`include "assert_macros.svh"

module queue_with_running_max #(
    parameter int DEPTH       = qrm_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = qrm_pkg::VALUE_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [qrm_pkg::IN_VALUE_W-1:0]  i_s_tdata,   // value
    input  logic                            i_s_tuser,   // operation
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [qrm_pkg::OUT_DATA_W-1:0]  o_m_tdata    // max, is_empty, fill, status
);
    import qrm_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                   w_accept;
    logic                   w_full, w_empty;
    logic [VALUE_WIDTH-1:0] w_value;
    logic [IN_VALUE_W+VALUE_WIDTH-1:0] w_in_ext;
    t_cell_cmd              w_cmd;
    t_status                w_status;

    logic                   r_out_valid;
    t_status                r_status;
    logic [PTR_W-1:0]       r_front, n_front;
    logic [PTR_W-1:0]       r_back, n_back;
    logic [CNT_W-1:0]       r_count, n_count;

    logic [DEPTH-1:0]       w_keep;
    logic [DEPTH-1:0]       w_cvalid;
    logic [VALUE_WIDTH-1:0] w_cvalue [DEPTH];
    logic [PTR_W-1:0]       w_ctag   [DEPTH];

    logic [MAX_W+VALUE_WIDTH-1:0] w_max_ext;
    logic [VALUE_WIDTH-1:0]       w_max;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_in_ext = {{VALUE_WIDTH{1'b0}}, i_s_tdata};
    assign w_value  = w_in_ext[VALUE_WIDTH-1:0];

    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_empty = (r_count == '0);

    always_comb begin
        w_cmd    = '0;
        w_status = ST_OK;
        n_front  = r_front;
        n_back   = r_back;
        n_count  = r_count;
        if (w_accept) begin
            if (i_s_tuser == OP_PUSH) begin
                if (w_full) begin
                    w_status = ST_PUSH_FULL;
                end else begin
                    w_cmd.push = 1'b1;
                    n_back     = (r_back == PTR_W'(DEPTH - 1)) ? '0 : r_back + 1'b1;
                    n_count    = r_count + 1'b1;
                end
            end else begin
                if (w_empty) begin
                    w_status = ST_POP_EMPTY;
                end else begin
                    // front candidate leaves only if it is the very entry being popped
                    w_cmd.shift = w_cvalid[0] && (w_ctag[0] == r_front);
                    n_front     = (r_front == PTR_W'(DEPTH - 1)) ? '0 : r_front + 1'b1;
                    n_count     = r_count - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_front     <= '0;
            r_back      <= '0;
            r_count     <= '0;
        end else begin
            if (o_s_tready) begin
                r_out_valid <= i_s_tvalid;
            end
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
        end
        if (w_accept) begin
            r_status <= w_status;
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                   w_prev_keep;
        logic                   w_next_valid;
        logic [VALUE_WIDTH-1:0] w_next_value;
        logic [PTR_W-1:0]       w_next_tag;

        if (i == 0) begin : g_first
            assign w_prev_keep = 1'b1;
        end else begin : g_mid
            assign w_prev_keep = w_keep[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign w_next_valid = 1'b0;
            assign w_next_value = '0;
            assign w_next_tag   = '0;
        end else begin : g_inner
            assign w_next_valid = w_cvalid[i+1];
            assign w_next_value = w_cvalue[i+1];
            assign w_next_tag   = w_ctag[i+1];
        end

        qrm_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .TAG_W       (PTR_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_new_value  (w_value),
            .i_new_tag    (r_back),
            .i_prev_keep  (w_prev_keep),
            .i_next_valid (w_next_valid),
            .i_next_value (w_next_value),
            .i_next_tag   (w_next_tag),
            .o_keep       (w_keep[i]),
            .o_valid      (w_cvalid[i]),
            .o_value      (w_cvalue[i]),
            .o_tag        (w_ctag[i])
        );
    end

    // Result reflects the state left by the last accepted transaction
    assign w_max     = w_empty ? '0 : w_cvalue[0];
    assign w_max_ext = {{MAX_W{w_max[VALUE_WIDTH-1]}}, w_max};

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_status,
                         FILL_W'({{FILL_W{1'b0}}, r_count}),
                         w_empty,
                         w_max_ext[MAX_W-1:0]};

    `QRM_ASSERT(a_cand_contiguous, ((w_cvalid & (w_cvalid + DEPTH'(1))) == '0), "candidate gap")
    `QRM_ASSERT_IMP(a_empty_no_cand, w_empty, (w_cvalid == '0), "candidates left in empty queue")
    `QRM_ASSERT_IMP(a_front_cand, !w_empty, w_cvalid[0], "nonempty queue without max")
    `QRM_ASSERT(a_count_range, (r_count <= CNT_W'(DEPTH)), "fill count overflow")

endmodule

// ===== rtl/qrm_cell.sv =====
// One slot of the candidate list: value, FIFO slot tag and valid bit.
module qrm_cell #(
    parameter int VALUE_WIDTH = qrm_pkg::VALUE_WIDTH_DEF,
    parameter int TAG_W       = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  qrm_pkg::t_cell_cmd     i_cmd,
    input  logic [VALUE_WIDTH-1:0] i_new_value,
    input  logic [TAG_W-1:0]       i_new_tag,
    input  logic                   i_prev_keep,
    input  logic                   i_next_valid,
    input  logic [VALUE_WIDTH-1:0] i_next_value,
    input  logic [TAG_W-1:0]       i_next_tag,
    output logic                   o_keep,
    output logic                   o_valid,
    output logic [VALUE_WIDTH-1:0] o_value,
    output logic [TAG_W-1:0]       o_tag
);
    logic                   r_valid, n_valid;
    logic [VALUE_WIDTH-1:0] r_value, n_value;
    logic [TAG_W-1:0]       r_tag, n_tag;

    // Survives a push when not strictly smaller than the new value
    assign o_keep = r_valid && ($signed(r_value) >= $signed(i_new_value));

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        n_tag   = r_tag;
        if (i_cmd.push) begin
            // first slot past the kept prefix takes the new value
            n_valid = o_keep || i_prev_keep;
            if (!o_keep) begin
                n_value = i_new_value;
                n_tag   = i_new_tag;
            end
        end else if (i_cmd.shift) begin
            n_valid = i_next_valid;
            n_value = i_next_value;
            n_tag   = i_next_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_value <= n_value;
        r_tag   <= n_tag;
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_tag   = r_tag;

endmodule
